[sv/cmqe_pkg.sv]
// Package for the CUT-mode quadrant encoder: character tables, codes and shared types.
package cmqe_pkg;

  localparam int QUAD_ENTRIES = 77;
  localparam int POS_W        = $clog2(QUAD_ENTRIES);

  localparam logic [2:0] QUAD_NONE = 3'd4;
  localparam logic [1:0] BIN_QUAD  = 2'd2;
  localparam logic [7:0] ZERO_CODE = 8'h41;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] SPACE_CHR = 8'h20;
  localparam logic [7:0] CR_CHAR   = 8'h0D;
  localparam logic [7:0] LF_CHAR   = 8'h0A;
  localparam logic [7:0] TAB_CHAR  = 8'h09;
  localparam logic [7:0] ALL_ONES  = 8'hFF;

  localparam logic [7:0] QUAD_ID [4] = '{8'h3B, 8'h3D, 8'h2A, 8'h27};

  localparam logic [7:0] ALPHABET [QUAD_ENTRIES] = '{
    " ", "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M", "N", "O",
    "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z", "a", "b", "c", "d", "e",
    "f", "g", "h", "i", "j", "k", "l", "m", "n", "o", "p", "q", "r", "s", "t", "u",
    "v", "w", "x", "y", "z", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "%",
    "&", "_", "(", ")", "<", "+", ",", "-", ".", "/", ":", ">", "?"
  };

  localparam logic [7:0] QUAD_TAB [4][QUAD_ENTRIES] = '{
    '{8'h40,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hd1,8'hd2,8'hd3,8'hd4,
      8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'h81,
      8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
      8'h97,8'h98,8'h99,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'hf0,8'hf1,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'h6c,8'h50,8'h6d,8'h4d,8'h5d,8'h4c,8'h4e,
      8'h6b,8'h60,8'h4b,8'h61,8'h7a,8'h6e,8'h6f},
    '{8'h20,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,
      8'h4e,8'h4f,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h61,
      8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,
      8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h30,8'h31,8'h32,
      8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h2b,
      8'h2c,8'h2d,8'h2e,8'h2f,8'h3a,8'h3b,8'h3f},
    '{8'h00,8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'h0c,
      8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3c,8'h3d,8'h3e,
      8'h00,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'hff,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h1a,8'h1b,
      8'h1c,8'h1d,8'h1e,8'h1f,8'h00,8'h00,8'h00},
    '{8'h00,8'ha0,8'ha1,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,8'he0,8'he1,8'haa,8'hab,8'hac,
      8'had,8'hae,8'haf,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'h80,
      8'h00,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hc0,8'h00,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,
      8'h8f,8'h90,8'h00,8'hda,8'hdb,8'hdc,8'hdd,8'hde,8'hdf,8'hd0,8'h00,8'h00,8'h21,8'h22,
      8'h23,8'h24,8'h5b,8'h5c,8'h00,8'h5e,8'h5f,8'h00,8'h9c,8'h9d,8'h9e,8'h9f,8'hba,8'hbb,
      8'hbc,8'hbd,8'hbe,8'hbf,8'h9a,8'h9b,8'h00}
  };

  localparam logic [7:0] EBC_TO_ASC [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h9c,8'h09,8'h86,8'h7f,8'h97,8'h8d,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
    8'h10,8'h11,8'h12,8'h13,8'h9d,8'h85,8'h08,8'h87,8'h18,8'h19,8'h92,8'h8f,8'h1c,8'h1d,8'h1e,8'h1f,
    8'h80,8'h81,8'h82,8'h83,8'h84,8'h00,8'h17,8'h1b,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h05,8'h06,8'h07,
    8'h90,8'h91,8'h16,8'h93,8'h94,8'h95,8'h96,8'h04,8'h98,8'h99,8'h9a,8'h9b,8'h14,8'h15,8'h9e,8'h1a,
    8'h20,8'ha0,8'ha1,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'h5b,8'h2e,8'h3c,8'h28,8'h2b,8'h5d,
    8'h26,8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,8'h21,8'h24,8'h2a,8'h29,8'h3b,8'h5e,
    8'h2d,8'h2f,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'h7c,8'h2c,8'h25,8'h5f,8'h3e,8'h3f,
    8'hba,8'hbb,8'hbc,8'hbd,8'hbe,8'hbf,8'hc0,8'hc1,8'hc2,8'h60,8'h3a,8'h23,8'h40,8'h27,8'h3d,8'h22,
    8'hc3,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,
    8'hca,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hd0,
    8'hd1,8'h7e,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,
    8'hd8,8'hd9,8'hda,8'hdb,8'hdc,8'hdd,8'hde,8'hdf,8'he0,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,
    8'h7b,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'he8,8'he9,8'hea,8'heb,8'hec,8'hed,
    8'h7d,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'hee,8'hef,8'hf0,8'hf1,8'hf2,8'hf3,
    8'h5c,8'h9f,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'hff
  };

  // Search result for one translated byte across all four quadrants.
  typedef struct packed {
    logic                       bin_zero;
    logic [3:0]                 hit;
    logic [3:0][POS_W-1:0]      pos;
  } lkp_t;

  typedef struct packed {
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic [1:0] char_count;
    logic       error;
    logic       last_of_block;
  } res_t;

  function automatic logic [7:0] alpha_char(logic [POS_W-1:0] p);
    logic [7:0] c;
    c = 8'h00;
    if (p < POS_W'(QUAD_ENTRIES)) c = ALPHABET[p];
    return c;
  endfunction

endpackage

[sv/cmqe_if.sv]
// Channel interfaces for host bytes in and encoded characters out.
interface cmqe_host_if;
  logic       valid;
  logic       ready;
  logic [7:0] host_byte;
  logic       end_of_block;
  modport source (output valid, host_byte, end_of_block, input ready);
  modport sink   (input valid, host_byte, end_of_block, output ready);
endinterface

interface cmqe_link_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_char;
  logic [7:0] second_char;
  logic [1:0] char_count;
  logic       error;
  logic       last_of_block;
  modport source (output valid, first_char, second_char, char_count, error, last_of_block,
                  input ready);
  modport sink   (input valid, first_char, second_char, char_count, error, last_of_block,
                  output ready);
endinterface

[sv/cmqe_xlat.sv]
// Byte translation and parallel search of the four quadrant tables.
module cmqe_xlat
  import cmqe_pkg::*;
(
  input  logic       ascii_mode,
  input  logic [7:0] host_byte,
  output lkp_t       lkp
);

  logic [7:0] sel;
  logic [7:0] val;

  always_comb begin
    sel = host_byte;
    if (host_byte == 8'h00) begin
      sel = DOT_CHAR;
    end else if (host_byte == CR_CHAR || host_byte == LF_CHAR) begin
      sel = host_byte;
    end else if (host_byte == TAB_CHAR) begin
      sel = SPACE_CHR;
    end else if (host_byte < SPACE_CHR || host_byte == ALL_ONES) begin
      sel = DOT_CHAR;
    end
    val = ascii_mode ? EBC_TO_ASC[sel] : host_byte;
  end

  // Every entry is compared at once; the downward scan leaves the lowest match.
  always_comb begin
    lkp.bin_zero = !ascii_mode && (host_byte == 8'h00);
    for (int q = 0; q < 4; q++) begin
      lkp.hit[q] = 1'b0;
      lkp.pos[q] = '0;
      for (int i = QUAD_ENTRIES - 1; i >= 0; i--) begin
        if (QUAD_TAB[q][i] == val) begin
          lkp.hit[q] = 1'b1;
          lkp.pos[q] = POS_W'(i);
        end
      end
    end
  end

endmodule

[sv/cmqe_encoder.sv]
// Quadrant state register, character selection and the result register.
module cmqe_encoder
  import cmqe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  lkp_t lkp,
  input  logic eob,
  output res_t res
);

  logic [2:0] cur_quad;
  logic [2:0] cur_quad_next;
  res_t       res_next;
  logic       found;

  always_comb begin
    cur_quad_next          = cur_quad;
    res_next               = '0;
    res_next.last_of_block = eob;
    found                  = 1'b0;
    if (lkp.bin_zero) begin
      if (cur_quad == {1'b0, BIN_QUAD}) begin
        res_next.first_char = ZERO_CODE;
        res_next.char_count = 2'd1;
      end else begin
        res_next.first_char  = QUAD_ID[BIN_QUAD];
        res_next.second_char = ZERO_CODE;
        res_next.char_count  = 2'd2;
        cur_quad_next        = {1'b0, BIN_QUAD};
      end
    end else if (!cur_quad[2] && lkp.hit[cur_quad[1:0]]) begin
      res_next.first_char = alpha_char(lkp.pos[cur_quad[1:0]]);
      res_next.char_count = 2'd1;
    end else begin
      // The current quadrant has already missed, so the first hit is never it.
      for (int q = 0; q < 4; q++) begin
        if (!found && lkp.hit[q]) begin
          found                = 1'b1;
          res_next.first_char  = QUAD_ID[q];
          res_next.second_char = alpha_char(lkp.pos[q]);
          res_next.char_count  = 2'd2;
          cur_quad_next        = {1'b0, 2'(q)};
        end
      end
      if (!found) begin
        res_next.error = 1'b1;
        cur_quad_next  = QUAD_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_quad <= QUAD_NONE;
    end else if (advance) begin
      cur_quad <= cur_quad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  a_quad_range: assert property (@(posedge clk) disable iff (rst)
    cur_quad[2] |-> cur_quad[1:0] == 2'd0)
    else $error("quadrant register holds an undefined code");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    advance |=> (!res.error || (res.char_count == 2'd0 && cur_quad == QUAD_NONE)))
    else $error("error result without cleared quadrant and empty count");

  a_switch_selects: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.char_count != 2'd2 || !cur_quad[2]))
    else $error("quadrant identifier sent but no quadrant selected");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.char_count != 2'd3 && (res.char_count == 2'd0) == res.error))
    else $error("character count disagrees with error flag");

endmodule

[sv/cut_mode_quadrant_encoder_unit.sv]
// Top level of the CUT-mode quadrant encoder.
//
// The host channel carries one byte and an end-of-block mark per request; the
// link channel returns one result per byte: up to two characters, their count,
// an error flag and the copied end-of-block mark. Both use valid/ready.
// A byte is captured in an input register, translated and searched in all
// four quadrant tables combinationally, and its result lands in the output
// register; one byte per cycle is sustained while the link takes each
// result. The quadrant register is updated as each byte moves into the
// output register, so bytes are encoded strictly in order.
// When the link stalls, the result and the byte behind it hold in place and
// host ready drops only once both registers are full.
// cfg_we with cfg_wdata writes the ASCII mode bit; write it only while the
// block is empty. Reset clears both valid flags, selects no quadrant and
// returns to binary mode.
module cut_mode_quadrant_encoder_unit
  import cmqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  cmqe_host_if.sink   host,
  cmqe_link_if.source link
);

  logic       ascii_mode;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eob;
  logic       out_valid;
  logic       out_free;
  logic       advance;
  lkp_t       lkp;
  res_t       res;

  assign out_free   = !out_valid || link.ready;
  assign advance    = s1_valid && out_free;
  assign host.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_mode <= 1'b0;
    end else if (cfg_we) begin
      ascii_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (host.ready) s1_valid <= host.valid;
      if (out_free) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (host.valid && host.ready) begin
      s1_byte <= host.host_byte;
      s1_eob  <= host.end_of_block;
    end
  end

  cmqe_xlat u_xlat (
    .ascii_mode (ascii_mode),
    .host_byte  (s1_byte),
    .lkp        (lkp)
  );

  cmqe_encoder u_enc (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .lkp     (lkp),
    .eob     (s1_eob),
    .res     (res)
  );

  assign link.valid         = out_valid;
  assign link.first_char    = res.first_char;
  assign link.second_char   = res.second_char;
  assign link.char_count    = res.char_count;
  assign link.error         = res.error;
  assign link.last_of_block = res.last_of_block;

endmodule

[tb/sv/tb.sv]
// Testbench for the CUT-mode quadrant encoder: random and directed host requests checked
// against an in-bench encoder model.
`timescale 1ns / 1ps

module tb;
  import cmqe_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SEG_ITEMS    = 225;

  typedef struct {
    logic [7:0] host_byte;
    logic       eob;
  } host_req_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  cmqe_host_if host ();
  cmqe_link_if link ();

  cut_mode_quadrant_encoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .host      (host.sink),
    .link      (link.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  host_req_t   pending_reqs[$];
  res_t        expected_chars[$];
  logic [2:0]  quad_sel = QUAD_NONE;
  logic        ascii_on = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned run_quad = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          host_fire = 1'b0;

  // First position of v in quadrant q, or QUAD_ENTRIES when it is absent.
  function automatic int quad_pos(int q, logic [7:0] v);
    for (int i = 0; i < QUAD_ENTRIES; i++) begin
      if (QUAD_TAB[q][i] == v) return i;
    end
    return QUAD_ENTRIES;
  endfunction

  function automatic res_t encode_host_byte(logic [7:0] b, logic eob);
    res_t       r;
    logic [7:0] sel;
    logic [7:0] v;
    int         pos;
    bit         done;
    r = '0;
    r.last_of_block = eob;
    if (quad_sel >= QUAD_NONE) quad_sel = QUAD_NONE;
    if (!ascii_on && b == 8'h00) begin
      if (quad_sel != {1'b0, BIN_QUAD}) begin
        quad_sel = {1'b0, BIN_QUAD};
        r.first_char = QUAD_ID[BIN_QUAD];
        r.second_char = ZERO_CODE;
        r.char_count = 2'd2;
      end else begin
        r.first_char = ZERO_CODE;
        r.char_count = 2'd1;
      end
      return r;
    end
    v = b;
    if (ascii_on) begin
      // The substitution tests look at the raw byte, not the translated one.
      sel = b;
      if (b == 8'h00) begin
        sel = DOT_CHAR;
      end else if (b == TAB_CHAR) begin
        sel = SPACE_CHR;
      end else if ((b < 8'h20 && b != CR_CHAR && b != LF_CHAR) || b == ALL_ONES) begin
        sel = DOT_CHAR;
      end
      v = EBC_TO_ASC[sel];
    end
    done = 1'b0;
    if (quad_sel < QUAD_NONE) begin
      pos = quad_pos(quad_sel, v);
      if (pos < QUAD_ENTRIES) begin
        r.first_char = ALPHABET[pos];
        r.char_count = 2'd1;
        done = 1'b1;
      end
    end
    for (int q = 0; q < 4 && !done; q++) begin
      if (q != quad_sel) begin
        pos = quad_pos(q, v);
        if (pos < QUAD_ENTRIES) begin
          quad_sel = 3'(q);
          r.first_char = QUAD_ID[q];
          r.second_char = ALPHABET[pos];
          r.char_count = 2'd2;
          done = 1'b1;
        end
      end
    end
    if (!done) begin
      quad_sel = QUAD_NONE;
      r.error = 1'b1;
    end
    return r;
  endfunction

  // Runs of bytes from one quadrant's table, with awkward bytes and noise mixed in.
  function automatic logic [7:0] pick_host_byte();
    logic [7:0] specials [8] = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'hFF, 8'h1F, 8'h20, 8'h25};
    int unsigned roll;
    roll = $urandom_range(99);
    if ($urandom_range(9) == 0) run_quad = $urandom_range(3);
    if (roll < 15) return specials[$urandom_range(7)];
    if (roll < 60) return QUAD_TAB[run_quad][$urandom_range(QUAD_ENTRIES - 1)];
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_req(logic [7:0] b, logic eob);
    host_req_t req;
    req.host_byte = b;
    req.eob = eob;
    pending_reqs.push_back(req);
  endtask

  task automatic write_mode(logic m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    ascii_on = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Returns once every request has gone in and every result has come back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || host.valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    host_req_t req;
    link.ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && (!host.valid || host_fire)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req = pending_reqs.pop_front();
        host.valid <= 1'b1;
        host.host_byte <= req.host_byte;
        host.end_of_block <= req.eob;
      end else begin
        host.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    host_fire = host.valid && host.ready;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** cut_mode_quadrant_encoder_unit: FAILED **");
      $finish;
    end else if (!rst) begin
      if (host_fire)
        expected_chars.push_back(encode_host_byte(host.host_byte, host.end_of_block));
      if (link.valid && link.ready) begin
        if (expected_chars.size() == 0) begin
          $error("result with no request outstanding: first_char %h", link.first_char);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (link.first_char !== want.first_char) begin
            $error("first_char: expected %h, got %h", want.first_char, link.first_char);
            fail_count++;
          end
          if (link.second_char !== want.second_char) begin
            $error("second_char: expected %h, got %h", want.second_char, link.second_char);
            fail_count++;
          end
          if (link.char_count !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count, link.char_count);
            fail_count++;
          end
          if (link.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, link.error);
            fail_count++;
          end
          if (link.last_of_block !== want.last_of_block) begin
            $error("last_of_block: expected %b, got %b", want.last_of_block,
                   link.last_of_block);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    host.valid = 1'b0;
    host.host_byte = 8'h00;
    host.end_of_block = 1'b0;
    link.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Binary mode: zero byte entering and already in quadrant 2, a byte found in the
    // current quadrant ahead of a lower one, and a visit to every quadrant.
    write_mode(1'b0);
    queue_req(8'h00, 1'b0);
    queue_req(8'h00, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'h40, 1'b0);
    queue_req(8'hC1, 1'b0);
    queue_req(8'h20, 1'b0);
    queue_req(8'h4B, 1'b0);
    queue_req(8'h40, 1'b0);
    queue_req(8'h4B, 1'b1);
    queue_req(8'h80, 1'b0);
    queue_req(8'h00, 1'b0);
    queue_req(8'h7F, 1'b1);
    wait_drained();

    // ASCII mode: each kind of substituted control byte, CR and LF passed through, and a byte
    // that translates to zero.
    write_mode(1'b1);
    queue_req(8'h00, 1'b0);
    queue_req(8'h0D, 1'b0);
    queue_req(8'h0A, 1'b0);
    queue_req(8'h09, 1'b0);
    queue_req(8'h05, 1'b0);
    queue_req(8'h1F, 1'b0);
    queue_req(8'hFF, 1'b1);
    queue_req(8'h25, 1'b0);
    queue_req(8'h20, 1'b0);
    queue_req(8'hC1, 1'b0);
    queue_req(8'hFE, 1'b1);
    wait_drained();

    for (int seg = 0; seg < 8; seg++) begin
      write_mode(seg[0]);
      case (seg >> 1)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int i = 0; i < SEG_ITEMS; i++)
        queue_req(pick_host_byte(), $urandom_range(15) == 0);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("** cut_mode_quadrant_encoder_unit: PASSED **");
    end else begin
      $display("** cut_mode_quadrant_encoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
